/* hw/rtl/tsppr_pkg.sv */
`timescale 1ns / 1ps
package tsppr_pkg;
	localparam int AmpW = 16;
	localparam int EnW = 24;
	localparam int TsW = 24;
	// exact mix products: 16x16 sums of two
	localparam int ZW = 34;
	// rotated values: z*gain/2^16 plus cordic growth
	localparam int RW = 36;
	localparam int PhW = 32;
	localparam int AtanEntries = 24;
	localparam int CordicStagesDef = 16;
	localparam logic [16:0] InvGain = 17'd39797;

	typedef logic [31:0] atan_tab_t [AtanEntries];
	localparam atan_tab_t AtanTab = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
		32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic signed [AmpW-1:0] amp0_re;
		logic signed [AmpW-1:0] amp0_im;
		logic signed [AmpW-1:0] amp1_re;
		logic signed [AmpW-1:0] amp1_im;
		logic signed [AmpW-1:0] mix_cos;
		logic signed [AmpW-1:0] mix_sin;
		logic signed [EnW-1:0] energy0;
		logic signed [EnW-1:0] energy1;
	} in_item_t;

	typedef struct packed {
		logic signed [AmpW-1:0] new0_re;
		logic signed [AmpW-1:0] new0_im;
		logic signed [AmpW-1:0] new1_re;
		logic signed [AmpW-1:0] new1_im;
	} out_item_t;

	// one cordic lane state
	typedef struct packed {
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
		logic signed [PhW-1:0] r;
	} rot_t;
endpackage

/* hw/rtl/tsppr_stream_if.sv */
`timescale 1ns / 1ps
interface tsppr_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/two_state_potential_phase_rotation_core.sv */
`timescale 1ns / 1ps
// Two-state potential phase rotation for one grid point a cycle unless the receiver stalls.
// Channels: in_req carries two Q1.14 complex amplitudes, the mixing cosine and
// sine and two Q8.16 energies; out_req carries the four saturated Q1.14 parts.
// Both use valid/ready; a request moves when both are high.
// cfg_we/cfg_wdata write time_step_turns (signed Q0.23 turns per energy unit);
// write it only while the pipeline is empty.
// Throughput: one request per cycle unless the receiver stalls; each cordic stage is one register stage,
// the mixing and phase multiplies share a stage and the gain multiply has its own.
// A stall at the receiver holds the whole pipeline in place (one shared
// enable), so nothing is lost or repeated; the input is ready whenever the
// output register is empty or being taken.
// Reset clears all valid bits and sets time_step_turns to zero.
module two_state_potential_phase_rotation_core import tsppr_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStagesDef
) (
	input logic clk,
	input logic arst_n,
	tsppr_stream_if.sink in_req,
	tsppr_stream_if.source out_req,
	input logic cfg_we,
	input logic [TsW-1:0] cfg_wdata
);
	localparam int NSt = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
	localparam int NV = NSt + 6;

	logic [TsW-1:0] ts_q;
	logic [NV-1:0] vld_q;
	logic adv;

	// stall: whole pipe moves together
	assign adv = !vld_q[NV-1] || out_req.ready;
	assign in_req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= '0;
		end else if (cfg_we) begin
			ts_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NV-2:0], in_req.valid};
		end
	end

	// stage 1: register input
	in_item_t in_s1;
	always_ff @(posedge clk) if (adv) in_s1 <= in_req.data;

	// stage 2: mix products and phase products
	logic signed [2*AmpW-1:0] m_s2 [8];
	logic signed [2*EnW-1:0] p0_s2, p1_s2;
	logic signed [AmpW-1:0] c_s2, s_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			m_s2[0] <= in_s1.mix_cos * in_s1.amp0_re;
			m_s2[1] <= in_s1.mix_sin * in_s1.amp1_re;
			m_s2[2] <= in_s1.mix_cos * in_s1.amp0_im;
			m_s2[3] <= in_s1.mix_sin * in_s1.amp1_im;
			m_s2[4] <= in_s1.mix_sin * in_s1.amp0_re;
			m_s2[5] <= in_s1.mix_cos * in_s1.amp1_re;
			m_s2[6] <= in_s1.mix_sin * in_s1.amp0_im;
			m_s2[7] <= in_s1.mix_cos * in_s1.amp1_im;
			p0_s2 <= in_s1.energy0 * $signed(ts_q);
			p1_s2 <= in_s1.energy1 * $signed(ts_q);
			c_s2 <= in_s1.mix_cos;
			s_s2 <= in_s1.mix_sin;
		end
	end

	// stage 3: eigenbasis sums, gain multiply, quadrant split
	logic signed [ZW-1:0] z_c [4];
	logic [PhW-1:0] ph [2];
	logic [1:0] qd [2];
	logic signed [ZW+17:0] g_s3 [4];
	logic [1:0] q_s3 [2];
	logic signed [PhW-1:0] r_s3 [2];
	logic signed [AmpW-1:0] c_s3, s_s3;
	always_comb begin
		z_c[0] = ZW'(m_s2[0]) - ZW'(m_s2[1]);
		z_c[1] = ZW'(m_s2[2]) - ZW'(m_s2[3]);
		z_c[2] = ZW'(m_s2[4]) + ZW'(m_s2[5]);
		z_c[3] = ZW'(m_s2[6]) + ZW'(m_s2[7]);
		ph[0] = p0_s2[38:7];
		ph[1] = p1_s2[38:7];
		for (int k = 0; k < 2; k++) qd[k] = 2'((ph[k] + 32'h20000000) >> 30);
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 4; k++) g_s3[k] <= z_c[k] * $signed({1'b0, InvGain});
			for (int k = 0; k < 2; k++) begin
				q_s3[k] <= qd[k];
				r_s3[k] <= ph[k] - {qd[k], 30'd0};
			end
			c_s3 <= c_s2;
			s_s3 <= s_s2;
		end
	end

	// stage 4: shift down gain, quarter-turn rotation
	rot_t cr [2][NSt+1];
	logic signed [AmpW-1:0] c_p [NSt+1];
	logic signed [AmpW-1:0] s_p [NSt+1];
	logic signed [RW-1:0] ga [4];
	always_comb for (int k = 0; k < 4; k++) ga[k] = RW'(g_s3[k] >>> 16);
	for (genvar k = 0; k < 2; k++) begin : g_qt
		always_ff @(posedge clk) begin
			if (adv) begin
				case (q_s3[k])
					2'd1: begin cr[k][0].x <= -ga[2*k+1]; cr[k][0].y <= ga[2*k]; end
					2'd2: begin cr[k][0].x <= -ga[2*k]; cr[k][0].y <= -ga[2*k+1]; end
					2'd3: begin cr[k][0].x <= ga[2*k+1]; cr[k][0].y <= -ga[2*k]; end
					default: begin cr[k][0].x <= ga[2*k]; cr[k][0].y <= ga[2*k+1]; end
				endcase
				cr[k][0].r <= r_s3[k];
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_p[0] <= c_s3;
			s_p[0] <= s_s3;
		end
	end

	// cordic stages, one register each
	for (genvar i = 0; i < NSt; i++) begin : g_st
		for (genvar k = 0; k < 2; k++) begin : g_ln
			rot_t nx;
			tsppr_cordic_stage #(.Idx(i)) u_st (.a(cr[k][i]), .o(nx));
			always_ff @(posedge clk) if (adv) cr[k][i+1] <= nx;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				c_p[i+1] <= c_p[i];
				s_p[i+1] <= s_p[i];
			end
		end
	end

	// back-mix products
	logic signed [RW+AmpW-1:0] b_s5 [8];
	rot_t z1, z2;
	logic signed [AmpW-1:0] cf, sf;
	assign z1 = cr[0][NSt];
	assign z2 = cr[1][NSt];
	assign cf = c_p[NSt];
	assign sf = s_p[NSt];
	always_ff @(posedge clk) begin
		if (adv) begin
			b_s5[0] <= cf * z1.x; b_s5[1] <= sf * z2.x;
			b_s5[2] <= cf * z1.y; b_s5[3] <= sf * z2.y;
			b_s5[4] <= cf * z2.x; b_s5[5] <= sf * z1.x;
			b_s5[6] <= cf * z2.y; b_s5[7] <= sf * z1.y;
		end
	end

	// round, shift, saturate into output register
	logic signed [RW+AmpW:0] sm [4];
	logic signed [RW+AmpW-28:0] sh [4];
	logic signed [AmpW-1:0] sat [4];
	localparam logic signed [RW+AmpW:0] Half = (RW+AmpW+1)'(1) <<< 27;
	always_comb begin
		sm[0] = b_s5[0] + b_s5[1] + Half;
		sm[1] = b_s5[2] + b_s5[3] + Half;
		sm[2] = b_s5[4] - b_s5[5] + Half;
		sm[3] = b_s5[6] - b_s5[7] + Half;
		for (int k = 0; k < 4; k++) begin
			sh[k] = sm[k][RW+AmpW:28];
			if (sh[k] > 32767) sat[k] = 16'sd32767;
			else if (sh[k] < -32768) sat[k] = -16'sd32768;
			else sat[k] = sh[k][AmpW-1:0];
		end
	end
	out_item_t o_s6;
	always_ff @(posedge clk) begin
		if (adv) begin
			o_s6.new0_re <= sat[0];
			o_s6.new0_im <= sat[1];
			o_s6.new1_re <= sat[2];
			o_s6.new1_im <= sat[3];
		end
	end
	assign out_req.valid = vld_q[NV-1];
	assign out_req.data = o_s6;

`ifndef NO_ASSERTIONS
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_req.valid && !out_req.ready) |-> !in_req.ready) else $error("ready under stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_req.valid && !out_req.ready) |=> out_req.valid) else $error("result dropped");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(in_req.ready && !vld_q[NV-2]) |=> !out_req.valid) else $error("invented result");
`endif
endmodule

/* hw/rtl/tsppr_cordic_stage.sv */
`timescale 1ns / 1ps
module tsppr_cordic_stage import tsppr_pkg::*; #(
	parameter int Idx = 0
) (
	input  rot_t a,
	output rot_t o
);
	logic [PhW-1:0] at;
	assign at = AtanTab[Idx];
	// one micro-rotation toward zero residual
	always_comb begin
		if (!a.r[PhW-1]) begin
			o.x = a.x - (a.y >>> Idx);
			o.y = a.y + (a.x >>> Idx);
			o.r = a.r - at;
		end else begin
			o.x = a.x + (a.y >>> Idx);
			o.y = a.y - (a.x >>> Idx);
			o.r = a.r + at;
		end
	end
endmodule

/* bench/tb_phase_rotation_if.sv */
`timescale 1ns / 1ps
// point and result channels come from the block's interface definition;
// this file only collects the bench-side payload helpers
package tb_phase_rotation_pkg;
	import tsppr_pkg::*;

	// random value in a signed range
	function automatic logic signed [31:0] rand_between(int lo, int hi);
		return $signed($urandom_range(hi - lo, 0)) + lo;
	endfunction
endpackage

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
	import tsppr_pkg::*;
	import tb_phase_rotation_pkg::*;

	localparam int Latency = CordicStagesDef + 6;
	localparam int CycleLimit = 2000000;

	// propagated-point checker
	class point_scoreboard;
		out_item_t pending[$];
		logic signed [TsW-1:0] step_turns;
		int errors;
		int checked;

		function new();
			pending = {};
			step_turns = '0;
			errors = 0;
			checked = 0;
		endfunction

		// phase word: bits 38..7 of energy times step
		function automatic logic [31:0] phase_word(logic signed [EnW-1:0] e);
			logic signed [47:0] p;
			p = 48'(e) * 48'(step_turns);
			return p[38:7];
		endfunction

		function automatic longint floor_shift(longint v, int k);
			return v >>> k;
		endfunction

		// gain, quarter turns, then cordic stages
		function automatic void spin(inout longint x, inout longint y, input logic [31:0] phi);
			logic [1:0] quad;
			logic [31:0] d;
			longint r, a, b, t, da, db;
			quad = 2'((phi + 32'h20000000) >> 30);
			d = phi - (32'(quad) << 30);
			r = longint'($signed(d));
			a = floor_shift(x * longint'(InvGain), 16);
			b = floor_shift(y * longint'(InvGain), 16);
			case (quad)
				2'd1: begin t = a; a = -b; b = t; end
				2'd2: begin a = -a; b = -b; end
				2'd3: begin t = a; a = b; b = -t; end
				default: ;
			endcase
			for (int i = 0; i < CordicStagesDef && i < AtanEntries; i++) begin
				da = floor_shift(b, i);
				db = floor_shift(a, i);
				if (r >= 0) begin
					a -= da; b += db; r -= longint'(AtanTab[i]);
				end else begin
					a += da; b -= db; r += longint'(AtanTab[i]);
				end
			end
			x = a;
			y = b;
		endfunction

		function automatic logic signed [15:0] round_sat(longint v);
			longint s;
			s = floor_shift(v + (longint'(1) << 27), 28);
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			return 16'(s);
		endfunction

		// predict the propagated point
		function void note_point(in_item_t pt);
			longint c, s, z1r, z1i, z2r, z2i;
			out_item_t res;
			c = pt.mix_cos;
			s = pt.mix_sin;
			z1r = c * pt.amp0_re - s * pt.amp1_re;
			z1i = c * pt.amp0_im - s * pt.amp1_im;
			z2r = s * pt.amp0_re + c * pt.amp1_re;
			z2i = s * pt.amp0_im + c * pt.amp1_im;
			spin(z1r, z1i, phase_word(pt.energy0));
			spin(z2r, z2i, phase_word(pt.energy1));
			res.new0_re = round_sat(c * z1r + s * z2r);
			res.new0_im = round_sat(c * z1i + s * z2i);
			res.new1_re = round_sat(c * z2r - s * z1r);
			res.new1_im = round_sat(c * z2i - s * z1i);
			pending.push_back(res);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (pending.size() == 0) begin
				$error("result with no point outstanding");
				errors++;
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.new0_re !== want.new0_re) begin
				$error("new0_re expected %0d actual %0d", want.new0_re, got.new0_re); errors++;
			end
			if (got.new0_im !== want.new0_im) begin
				$error("new0_im expected %0d actual %0d", want.new0_im, got.new0_im); errors++;
			end
			if (got.new1_re !== want.new1_re) begin
				$error("new1_re expected %0d actual %0d", want.new1_re, got.new1_re); errors++;
			end
			if (got.new1_im !== want.new1_im) begin
				$error("new1_im expected %0d actual %0d", want.new1_im, got.new1_im); errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [TsW-1:0] cfg_wdata = '0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	int sent = 0;
	point_scoreboard board;

	tsppr_stream_if #(.payload_t(in_item_t)) in_req ();
	tsppr_stream_if #(.payload_t(out_item_t)) out_req ();

	two_state_potential_phase_rotation_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_req(in_req),
		.out_req(out_req),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_req.valid = 1'b0;
		in_req.data = '0;
		out_req.ready = 1'b0;
		board = new();
	end

	// receiver: random stalls, check on accept
	always @(posedge clk) begin
		if (arst_n && out_req.valid && out_req.ready) board.check_result(out_req.data);
		if (arst_n) out_req.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// send one point, with random idle before it
	task automatic send_point(in_item_t pt);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_req.valid <= 1'b0;
			@(posedge clk);
		end
		in_req.valid <= 1'b1;
		in_req.data <= pt;
		@(posedge clk);
		while (!in_req.ready) @(posedge clk);
		board.note_point(pt);
		sent++;
	endtask

	task automatic drain();
		in_req.valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic write_step(logic [TsW-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.step_turns = v;
		@(posedge clk);
	endtask

	function automatic in_item_t random_point(bit full_mix);
		in_item_t pt;
		pt.amp0_re = 16'($urandom);
		pt.amp0_im = 16'($urandom);
		pt.amp1_re = 16'($urandom);
		pt.amp1_im = 16'($urandom);
		pt.mix_cos = full_mix ? 16'($urandom) : 16'(rand_between(-16384, 16384));
		pt.mix_sin = full_mix ? 16'($urandom) : 16'(rand_between(-16384, 16384));
		pt.energy0 = 24'($urandom);
		pt.energy1 = 24'($urandom);
		return pt;
	endfunction

	// directed points: field extremes and mix corners
	task automatic directed_points();
		in_item_t pt;
		logic signed [15:0] amp_x[3] = '{16'sh7fff, -16'sh8000, 16'sd0};
		logic signed [15:0] mix_x[5] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sh7fff, -16'sh8000};
		logic signed [23:0] en_x[3] = '{24'sh7fffff, -24'sh800000, 24'sd0};
		for (int i = 0; i < 15; i++) begin
			pt.amp0_re = amp_x[i % 3];
			pt.amp0_im = amp_x[(i + 1) % 3];
			pt.amp1_re = amp_x[(i + 2) % 3];
			pt.amp1_im = amp_x[i % 3];
			pt.mix_cos = mix_x[i % 5];
			pt.mix_sin = mix_x[(i / 3) % 5];
			pt.energy0 = en_x[i % 3];
			pt.energy1 = en_x[(i / 5) % 3];
			send_point(pt);
		end
	endtask

	task automatic random_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		for (int i = 0; i < n; i++) send_point(random_point($urandom_range(9, 0) == 0));
	endtask

	// stimulus sequence
	initial begin
		logic [TsW-1:0] steps[5] = '{24'h7fffff, 24'h800000, 24'h000001, 24'hffffff, 24'h0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset value of the step first
		directed_points();
		drain();
		foreach (steps[k]) begin
			write_step(k == 4 ? 24'($urandom) : steps[k]);
			directed_points();
			drain();
		end
		for (int ph = 0; ph < 4; ph++) begin
			write_step(24'($urandom));
			random_phase(60, 0, 0);
			random_phase(20, 88, 0);
			random_phase(60, 0, 88);
			random_phase(60, 10, 10);
			// pause until everything is back
			drain();
		end
		$display("covered %0d points, %0d results checked, step settings incl. both extremes",
			sent, board.checked);
		$display("idle phases: none, sender 88%%, receiver 88%%, both 10%%");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

/* files.f */
hw/rtl/tsppr_pkg.sv
hw/rtl/tsppr_stream_if.sv
hw/rtl/tsppr_cordic_stage.sv
hw/rtl/two_state_potential_phase_rotation_core.sv
bench/tb_phase_rotation_if.sv
bench/tb_top.sv
